FILE: rtl/zss_pkg.sv
// ----------------------------------------------------------------------------
// zss_pkg
// Shared types and constants of the zoom step scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package zss_pkg;

  // Steps per request are clamped to this ceiling
  localparam int unsigned MAX_STEPS   = 64;
  localparam int unsigned NSTEP_W     = 7;
  localparam int unsigned MARGIN_W    = 11;
  localparam int unsigned HEIGHT_W    = 16;
  localparam int unsigned COORD_W     = 21;
  localparam int unsigned ZOOM_W      = 10;
  localparam int unsigned VIEW_W      = 48;
  localparam int unsigned WORD_W      = 64;
  // Span ends after margin fit in this many signed bits
  localparam int unsigned SPAN_W      = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  // Margin is given in 1024ths and applied on each side, hence 2 * 1024
  localparam int unsigned MARGIN_SHIFT = 11;
  localparam int unsigned ZOOM_DIVISOR = 10;
  localparam int signed   MIN_POINTER_X = 2;

  localparam logic [NSTEP_W-1:0]  NUM_STEPS_RST     = NSTEP_W'(32);
  localparam logic [MARGIN_W-1:0] SAFETY_MARGIN_RST = MARGIN_W'(25);
  localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = HEIGHT_W'(4096);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STEPS     = 2'd0,
    CFG_SAFETY_MARGIN = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [NSTEP_W-1:0]  num_steps;
    logic [MARGIN_W-1:0] safety_margin;
    logic [HEIGHT_W-1:0] screen_height;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic                     equal_span;
    logic signed [SPAN_W-1:0] y1;
    logic signed [SPAN_W-1:0] y2;
    logic [ZOOM_W-1:0]        zoom;
    logic signed [VIEW_W-1:0] view_low;
    logic signed [VIEW_W-1:0] view_high;
  } req_t;

  // Back-end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EQ,
    ST_CMUL,
    ST_CDIV,
    ST_DSEL,
    ST_R1MUL,
    ST_R1DIV,
    ST_R2MUL,
    ST_R2DIV,
    ST_ZMUL,
    ST_ZCMP,
    ST_CAP1MUL,
    ST_CAP2MUL,
    ST_CAPDIV,
    ST_PMUL_L,
    ST_PMUL_H,
    ST_SDIV,
    ST_EMIT
  } back_state_e;

endpackage

`default_nettype wire

FILE: rtl/zoom_step_scheduler.sv
// ----------------------------------------------------------------------------
// zoom_step_scheduler
// Click-to-zoom planner: fits the widened pointer span onto the screen and
// emits num_steps (clamped 1..64) interpolated view intervals to the target.
// ----------------------------------------------------------------------------
// A request is taken into a two-deep queue and handled one at a time. A full
// request (fixed point, fit and zoom cap) spends its setup in the shared
// bit-serial 64-bit divider (three divisions) and the shared multiplier;
// an equal-span request skips the divider and a degenerate one uses it
// once. Each emitted step is then computed in the four-bit-per-cycle step
// dividers and loaded into the output register, so the cost of a request
// grows with num_steps while the output is not stalled. The output register
// holds one step beat while the next one is computed. Configuration is
// always ready.
`default_nettype none

module zoom_step_scheduler (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [zss_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [zss_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [zss_pkg::COORD_W-1:0]   pointer_x_i,
  input  wire logic signed [zss_pkg::COORD_W-1:0]   pointer_y_i,
  input  wire logic [zss_pkg::ZOOM_W-1:0]           max_zoom_tenths_i,
  input  wire logic signed [zss_pkg::VIEW_W-1:0]    view_low_i,
  input  wire logic signed [zss_pkg::VIEW_W-1:0]    view_high_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [zss_pkg::VIEW_W-1:0]         step_low_o,
  output logic signed [zss_pkg::VIEW_W-1:0]         step_high_o,
  output logic                                      last_step_o,
  output logic                                      geometry_fault_o
);
  import zss_pkg::*;

  cfg_t cfg_q;
  req_t front_req, queue_req;
  logic push, full, pop, queue_valid;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_steps     <= NUM_STEPS_RST;
      cfg_q.safety_margin <= SAFETY_MARGIN_RST;
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_STEPS:     cfg_q.num_steps     <= cfg_data_i[NSTEP_W-1:0];
        CFG_SAFETY_MARGIN: cfg_q.safety_margin <= cfg_data_i[MARGIN_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  zss_front u_front (
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pointer_x_i       (pointer_x_i),
    .pointer_y_i       (pointer_y_i),
    .max_zoom_tenths_i (max_zoom_tenths_i),
    .view_low_i        (view_low_i),
    .view_high_i       (view_high_i),
    .push_o            (push),
    .req_o             (front_req),
    .full_i            (full)
  );

  zss_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_req),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .data_o      (queue_req)
  );

  zss_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (queue_valid),
    .q_data_i         (queue_req),
    .q_pop_o          (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .step_low_o       (step_low_o),
    .step_high_o      (step_high_o),
    .last_step_o      (last_step_o),
    .geometry_fault_o (geometry_fault_o)
  );

endmodule

`default_nettype wire

FILE: rtl/zss_front.sv
// ----------------------------------------------------------------------------
// zss_front
// Accepts requests, widens the pointer span by the margin and flags the
// equal-span case before the request enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module zss_front (
  input  wire zss_pkg::cfg_t                   cfg_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [zss_pkg::COORD_W-1:0] pointer_x_i,
  input  wire logic signed [zss_pkg::COORD_W-1:0] pointer_y_i,
  input  wire logic [zss_pkg::ZOOM_W-1:0]      max_zoom_tenths_i,
  input  wire logic signed [zss_pkg::VIEW_W-1:0]  view_low_i,
  input  wire logic signed [zss_pkg::VIEW_W-1:0]  view_high_i,
  output logic                                 push_o,
  output zss_pkg::req_t                        req_o,
  input  wire logic                            full_i
);
  import zss_pkg::*;

  logic [MARGIN_W+HEIGHT_W-1:0] margin_prod;
  logic [HEIGHT_W-1:0]          ds;
  logic signed [COORD_W-1:0]    x_cl;
  logic signed [SPAN_W-1:0]     y1, y2;
  logic signed [SPAN_W+1:0]     y2_minus_h;

  // Margin in coordinate units
  assign margin_prod = (MARGIN_W+HEIGHT_W)'(cfg_i.safety_margin)
                     * (MARGIN_W+HEIGHT_W)'(cfg_i.screen_height);
  assign ds = margin_prod[MARGIN_SHIFT +: HEIGHT_W];

  // Pointer x is raised to the minimum
  assign x_cl = (pointer_x_i < COORD_W'(MIN_POINTER_X)) ? COORD_W'(MIN_POINTER_X)
                                                          : pointer_x_i;

  // Span ends
  assign y1 = SPAN_W'(pointer_y_i) - SPAN_W'(x_cl)
            - $signed({{(SPAN_W-HEIGHT_W){1'b0}}, ds});
  assign y2 = SPAN_W'(pointer_y_i) + SPAN_W'(x_cl)
            + $signed({{(SPAN_W-HEIGHT_W){1'b0}}, ds});
  assign y2_minus_h = (SPAN_W+2)'(y2)
                    - $signed({{(SPAN_W+2-HEIGHT_W){1'b0}}, cfg_i.screen_height});

  // Request beat towards the queue
  always_comb begin
    req_o.equal_span = ((SPAN_W+2)'(y1) == y2_minus_h);
    req_o.y1         = y1;
    req_o.y2         = y2;
    req_o.zoom       = max_zoom_tenths_i;
    req_o.view_low   = view_low_i;
    req_o.view_high  = view_high_i;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

`default_nettype wire

FILE: rtl/zss_queue.sv
// ----------------------------------------------------------------------------
// zss_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module zss_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire zss_pkg::req_t push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output zss_pkg::req_t data_o
);
  import zss_pkg::*;

  req_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: rtl/zss_mul.sv
// ----------------------------------------------------------------------------
// zss_mul
// 64 x 64 multiplier, low 64 bits, one 16-bit slice of b per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module zss_mul (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [zss_pkg::WORD_W-1:0]   a_i,
  input  wire logic [zss_pkg::WORD_W-1:0]   b_i,
  output logic                              done_o,
  output logic [zss_pkg::WORD_W-1:0]        p_o
);
  import zss_pkg::*;

  logic [WORD_W-1:0]    a_q, b_q, acc_q;
  logic [WORD_W+15:0]   part;
  logic [1:0]           cnt_q;
  logic                 busy_q, done_q;

  assign part   = (WORD_W+16)'(a_q) * (WORD_W+16)'(b_q[15:0]);
  assign done_o = done_q;
  assign p_o    = acc_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) busy_q <= 1'b0;
      end
    end
  end

  // Shift-and-accumulate datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part[WORD_W-1:0];
      a_q   <= {a_q[WORD_W-17:0], 16'd0};
      b_q   <= {16'd0, b_q[WORD_W-1:16]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/zss_div.sv
// ----------------------------------------------------------------------------
// zss_div
// Signed 64-bit divider, truncating, one quotient bit per cycle.
// A zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module zss_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [zss_pkg::WORD_W-1:0] a_i,
  input  wire logic [zss_pkg::WORD_W-1:0] b_i,
  output logic                            done_o,
  output logic [zss_pkg::WORD_W-1:0]      q_o
);
  import zss_pkg::*;

  logic [WORD_W-1:0] ub_q, rem_q, quo_q, res_q;
  logic [WORD_W-1:0] rem_sh, rem_d, quo_d;
  logic              neg_q, zero_q, busy_q, done_q, qbit;
  logic [5:0]        cnt_q;

  // One restoring step
  always_comb begin
    rem_sh = {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
    qbit   = (rem_sh >= ub_q);
    rem_d  = qbit ? (rem_sh - ub_q) : rem_sh;
    quo_d  = {quo_q[WORD_W-2:0], qbit};
  end

  assign done_o = done_q;
  assign q_o    = res_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  // Magnitudes, iteration and signed result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= a_i[WORD_W-1] ? (-a_i) : a_i;
      ub_q   <= b_i[WORD_W-1] ? (-b_i) : b_i;
      rem_q  <= '0;
      neg_q  <= a_i[WORD_W-1] ^ b_i[WORD_W-1];
      zero_q <= (b_i == '0);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == 6'd63) begin
        res_q <= zero_q ? '0 : (neg_q ? (-quo_d) : quo_d);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/zss_ndiv.sv
// ----------------------------------------------------------------------------
// zss_ndiv
// Signed 64-bit dividend over a small positive divisor (1..127), truncating,
// four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module zss_ndiv (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [zss_pkg::WORD_W-1:0]  a_i,
  input  wire logic [zss_pkg::NSTEP_W-1:0] n_i,
  output logic                             done_o,
  output logic [zss_pkg::WORD_W-1:0]       q_o
);
  import zss_pkg::*;

  logic [WORD_W-1:0]  quo_q, res_q, quo_d;
  logic [NSTEP_W-1:0] n_q, rem_q, rem_d;
  logic               neg_q, busy_q, done_q;
  logic [3:0]         cnt_q;

  // Four restoring steps on the narrow remainder
  always_comb begin
    logic [NSTEP_W:0] r;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < 4; i++) begin
      r = {rem_d, quo_d[WORD_W-1]};
      quo_d = {quo_d[WORD_W-2:0], 1'b0};
      if (r >= {1'b0, n_q}) begin
        r = r - {1'b0, n_q};
        quo_d[0] = 1'b1;
      end
      rem_d = r[NSTEP_W-1:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = res_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'd15);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) busy_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= a_i[WORD_W-1] ? (-a_i) : a_i;
      n_q   <= n_i;
      rem_q <= '0;
      neg_q <= a_i[WORD_W-1];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == 4'd15) res_q <= neg_q ? (-quo_d) : quo_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/zss_back.sv
// ----------------------------------------------------------------------------
// zss_back
// Sequencer that solves the fixed point, fits and caps the target interval
// and emits the interpolated steps through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zss_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire zss_pkg::cfg_t                    cfg_i,
  input  wire logic                             q_valid_i,
  input  wire zss_pkg::req_t                    q_data_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [zss_pkg::VIEW_W-1:0]     step_low_o,
  output logic signed [zss_pkg::VIEW_W-1:0]     step_high_o,
  output logic                                  last_step_o,
  output logic                                  geometry_fault_o
);
  import zss_pkg::*;

  back_state_e state_q, state_d;
  logic        launched_q;

  // Request and working registers
  logic signed [WORD_W-1:0] y1_q, y2_q, vl_q, vh_q, c_q, d_q, f_q;
  logic signed [WORD_W-1:0] r1_q, r2_q, tmp_q, tmp2_q;
  logic signed [WORD_W-1:0] pl_q, ph_q, dl_q, dh_q, lo_q, hi_q;
  logic [ZOOM_W-1:0]        zoom_q;
  logic                     fault_q;
  logic [NSTEP_W-1:0]       s_q, n_eff;

  // Unit handshakes
  logic                     mul_start, div_start, nd_start;
  logic                     mul_done, div_done, nd_done, nd_lo_done, nd_hi_done;
  logic [WORD_W-1:0]        mul_a, mul_b, mul_p, div_a, div_b, div_q;
  logic [WORD_W-1:0]        ndl_a, ndh_a, ndl_q, ndh_q;
  logic [NSTEP_W-1:0]       nd_n;

  logic signed [WORD_W-1:0] height, zoom64, span_new, ten_span;
  logic                     slot_free, emit_fire, is_fault, cap_hit;
  logic                     out_valid_q;

  // Effective step count
  always_comb begin
    if (cfg_i.num_steps == '0)                    n_eff = NSTEP_W'(1);
    else if (cfg_i.num_steps > NSTEP_W'(MAX_STEPS)) n_eff = NSTEP_W'(MAX_STEPS);
    else                                          n_eff = cfg_i.num_steps;
  end

  assign height   = $signed({{(WORD_W-HEIGHT_W){1'b0}}, cfg_i.screen_height});
  assign zoom64   = $signed({{(WORD_W-ZOOM_W){1'b0}}, zoom_q});
  assign is_fault = (y1_q == c_q) && (y2_q == c_q);
  assign span_new = r2_q - r1_q;
  assign ten_span = (span_new <<< 3) + (span_new <<< 1);
  assign cap_hit  = ten_span > $signed(tmp_q);

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit_fire = (state_q == ST_EMIT) && slot_free;

  // Both step dividers run in lockstep
  assign nd_done = nd_lo_done && nd_hi_done;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (q_valid_i) state_d = q_data_i.equal_span ? ST_EQ : ST_CMUL;
      ST_EQ:      state_d = ST_PMUL_L;
      ST_CMUL:    if (mul_done) state_d = ST_CDIV;
      ST_CDIV:    if (div_done) state_d = ST_DSEL;
      ST_DSEL:    state_d = is_fault ? ST_PMUL_L : ST_R1MUL;
      ST_R1MUL:   if (mul_done) state_d = ST_R1DIV;
      ST_R1DIV:   if (div_done) state_d = ST_R2MUL;
      ST_R2MUL:   if (mul_done) state_d = ST_R2DIV;
      ST_R2DIV:   if (div_done) state_d = (zoom_q != '0) ? ST_ZMUL : ST_PMUL_L;
      ST_ZMUL:    if (mul_done) state_d = ST_ZCMP;
      ST_ZCMP:    state_d = cap_hit ? ST_CAP1MUL : ST_PMUL_L;
      ST_CAP1MUL: if (mul_done) state_d = ST_CAP2MUL;
      ST_CAP2MUL: if (mul_done) state_d = ST_CAPDIV;
      ST_CAPDIV:  if (nd_done) state_d = ST_PMUL_L;
      ST_PMUL_L:  if (mul_done) state_d = ST_PMUL_H;
      ST_PMUL_H:  if (mul_done) state_d = ST_SDIV;
      ST_SDIV:    if (nd_done) state_d = ST_EMIT;
      ST_EMIT:    if (slot_free) state_d = (s_q == '0) ? ST_IDLE : ST_SDIV;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Unit launches and operand selection
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    nd_start  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_a     = tmp_q;
    div_b     = d_q;
    ndl_a     = pl_q;
    ndh_a     = ph_q;
    nd_n      = n_eff;
    q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
    case (state_q)
      ST_CMUL: begin
        mul_start = !launched_q;
        mul_a     = y1_q;
        mul_b     = height;
      end
      ST_CDIV: begin
        div_start = !launched_q;
        div_b     = y1_q + height - y2_q;
      end
      ST_R1MUL: begin
        mul_start = !launched_q;
        mul_a     = vl_q - c_q;
        mul_b     = f_q;
      end
      ST_R2MUL: begin
        mul_start = !launched_q;
        mul_a     = vh_q - c_q;
        mul_b     = f_q;
      end
      ST_R1DIV, ST_R2DIV: div_start = !launched_q;
      ST_ZMUL: begin
        mul_start = !launched_q;
        mul_a     = zoom64;
        mul_b     = vh_q - vl_q;
      end
      ST_CAP1MUL: begin
        mul_start = !launched_q;
        mul_a     = vl_q - c_q;
        mul_b     = zoom64;
      end
      ST_CAP2MUL: begin
        mul_start = !launched_q;
        mul_a     = vh_q - c_q;
        mul_b     = zoom64;
      end
      ST_CAPDIV: begin
        nd_start = !launched_q;
        ndl_a    = tmp_q;
        ndh_a    = tmp2_q;
        nd_n     = NSTEP_W'(ZOOM_DIVISOR);
      end
      ST_PMUL_L: begin
        mul_start = !launched_q;
        mul_a     = WORD_W'(n_eff - NSTEP_W'(1));
        mul_b     = r1_q - vl_q;
      end
      ST_PMUL_H: begin
        mul_start = !launched_q;
        mul_a     = WORD_W'(n_eff - NSTEP_W'(1));
        mul_b     = r2_q - vh_q;
      end
      ST_SDIV:  nd_start = !launched_q;
      default: ;
    endcase
  end

  // State and launch flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q)                   launched_q <= 1'b0;
      else if (mul_start || div_start || nd_start) launched_q <= 1'b1;
    end
  end

  // Working datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (q_valid_i) begin
        y1_q    <= WORD_W'(q_data_i.y1);
        y2_q    <= WORD_W'(q_data_i.y2);
        zoom_q  <= q_data_i.zoom;
        vl_q    <= WORD_W'(q_data_i.view_low);
        vh_q    <= WORD_W'(q_data_i.view_high);
        fault_q <= 1'b0;
      end
      ST_EQ: begin
        r1_q <= vl_q + y1_q;
        r2_q <= vh_q + y1_q;
      end
      ST_CMUL, ST_R1MUL, ST_R2MUL, ST_ZMUL, ST_CAP1MUL:
        if (mul_done) tmp_q <= $signed(mul_p);
      ST_CAP2MUL: if (mul_done) tmp2_q <= $signed(mul_p);
      ST_CDIV:    if (div_done) c_q <= $signed(div_q);
      ST_DSEL: begin
        if (y1_q != c_q) begin
          d_q <= y1_q - c_q;
          f_q <= -c_q;
        end else if (y2_q != c_q) begin
          d_q <= y2_q - c_q;
          f_q <= height - c_q;
        end else begin
          fault_q <= 1'b1;
          r1_q    <= vl_q;
          r2_q    <= vh_q;
        end
      end
      ST_R1DIV: if (div_done) r1_q <= $signed(div_q) + c_q;
      ST_R2DIV: if (div_done) r2_q <= $signed(div_q) + c_q;
      ST_CAPDIV: if (nd_done) begin
        r1_q <= $signed(ndl_q) + c_q;
        r2_q <= $signed(ndh_q) + c_q;
      end
      ST_PMUL_L: if (mul_done) begin
        pl_q <= $signed(mul_p);
        dl_q <= r1_q - vl_q;
        dh_q <= r2_q - vh_q;
        s_q  <= n_eff - NSTEP_W'(1);
      end
      ST_PMUL_H: if (mul_done) ph_q <= $signed(mul_p);
      ST_SDIV: if (nd_done) begin
        lo_q <= r1_q - $signed(ndl_q);
        hi_q <= r2_q - $signed(ndh_q);
      end
      ST_EMIT: if (slot_free && (s_q != '0)) begin
        s_q  <= s_q - NSTEP_W'(1);
        pl_q <= pl_q - dl_q;
        ph_q <= ph_q - dh_q;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      step_low_o       <= lo_q[VIEW_W-1:0];
      step_high_o      <= hi_q[VIEW_W-1:0];
      last_step_o      <= (s_q == '0);
      geometry_fault_o <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Shared units
  zss_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  zss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  zss_ndiv u_ndiv_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nd_start),
    .a_i     (ndl_a),
    .n_i     (nd_n),
    .done_o  (nd_lo_done),
    .q_o     (ndl_q)
  );

  zss_ndiv u_ndiv_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nd_start),
    .a_i     (ndh_a),
    .n_i     (nd_n),
    .done_o  (nd_hi_done),
    .q_o     (ndh_q)
  );

endmodule

`default_nettype wire

FILE: rtl/zss_checker.sv
// ----------------------------------------------------------------------------
// zss_checker
// Port-level checks of the zoom step scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module zss_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               cfg_ready_o,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic signed [zss_pkg::VIEW_W-1:0]  step_low_o,
  input wire logic signed [zss_pkg::VIEW_W-1:0]  step_high_o,
  input wire logic                               last_step_o,
  input wire logic                               geometry_fault_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(step_low_o)
      && $stable(step_high_o) && $stable(last_step_o) && $stable(geometry_fault_o))
    else $error("stalled result beat changed");

  // A result beat is only withdrawn once taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result beat dropped without being taken");

  // The queue only fills on an accepted request beat
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without a request beat");

  // Configuration is never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind zoom_step_scheduler zss_checker u_zss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_ready_o      (cfg_ready_o),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .step_low_o       (step_low_o),
  .step_high_o      (step_high_o),
  .last_step_o      (last_step_o),
  .geometry_fault_o (geometry_fault_o)
);

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zoom step scheduler. Zoom requests are driven
// under random idling and one long output hold-off. Every accepted request is
// expanded by a local planner into its expected step beats, and each output
// beat is compared field by field with the oldest expectation. The run goes
// through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import zss_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int unsigned          STALL_HOLD    = 3000;
  localparam int unsigned          IDLE_LIMIT    = 20000;

  typedef struct {
    logic signed [VIEW_W-1:0] lo;
    logic signed [VIEW_W-1:0] hi;
    logic                     last;
    logic                     fault;
  } zoom_step_t;

  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [ZOOM_W-1:0]         zoom;
    logic signed [VIEW_W-1:0]  vlo;
    logic signed [VIEW_W-1:0]  vhi;
    logic                      has_tgt;
    logic signed [VIEW_W-1:0]  tgt_lo;
    logic signed [VIEW_W-1:0]  tgt_hi;
  } zoom_req_t;

  typedef bit bool_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] pointer_x_i = '0;
  logic signed [COORD_W-1:0] pointer_y_i = '0;
  logic [ZOOM_W-1:0] max_zoom_tenths_i = '0;
  logic signed [VIEW_W-1:0] view_low_i = '0;
  logic signed [VIEW_W-1:0] view_high_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [VIEW_W-1:0] step_low_o;
  logic signed [VIEW_W-1:0] step_high_o;
  logic last_step_o;
  logic geometry_fault_o;

  // Local copy of the register file
  logic [NSTEP_W-1:0]  sh_num_steps  = NUM_STEPS_RST;
  logic [MARGIN_W-1:0] sh_margin     = SAFETY_MARGIN_RST;
  logic [HEIGHT_W-1:0] sh_height     = SCREEN_HEIGHT_RST;

  zoom_step_t pending_steps[$];
  int unsigned n_errors   = 0;
  int unsigned n_req_acc  = 0;
  int unsigned n_beats    = 0;
  bool_t       no_idle;
  int unsigned idle_cycles = 0;

  zoom_step_scheduler u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Truncating division with the zero and overflow corners pinned down
  function automatic longint tdiv(longint a, longint b);
    if (b == 0) return 0;
    if (b == -1) return 0 - a;
    return a / b;
  endfunction

  // Expand one request into its step beats
  function automatic void plan_zoom(zoom_req_t r);
    longint x, y, zm, v1, v2, h, n, y1, y2, ds, c, t1, t2, d, f, s, lo, hi;
    logic   fault;
    zoom_step_t st;
    x  = longint'(r.px);
    y  = longint'(r.py);
    zm = longint'({1'b0, r.zoom});
    v1 = longint'(r.vlo);
    v2 = longint'(r.vhi);
    h  = longint'({1'b0, sh_height});
    n  = longint'({1'b0, sh_num_steps});
    fault = 1'b0;
    if (n < 1) n = 1;
    if (n > MAX_STEPS) n = MAX_STEPS;
    if (x < 2) x = 2;
    ds = (longint'({1'b0, sh_margin}) * h) / 2048;
    y1 = y - x - ds;
    y2 = y + x + ds;
    if (y1 == y2 - h) begin
      c  = y1;
      t1 = v1 + c;
      t2 = v2 + c;
    end else begin
      c = tdiv(y1 * h, y1 + h - y2);
      if (y1 != c) begin
        d = y1 - c;
        f = 0 - c;
      end else begin
        d = y2 - c;
        f = h - c;
      end
      if (y1 != c || y2 != c) begin
        t1 = tdiv((v1 - c) * f, d) + c;
        t2 = tdiv((v2 - c) * f, d) + c;
      end else begin
        t1 = v1;
        t2 = v2;
        fault = 1'b1;
      end
      if (!fault && zm != 0 && (10 * (t2 - t1)) > (zm * (v2 - v1))) begin
        t1 = tdiv((v1 - c) * zm, 10) + c;
        t2 = tdiv((v2 - c) * zm, 10) + c;
      end
    end
    for (s = n - 1; s >= 0; s--) begin
      lo = t1 - tdiv(s * (t1 - v1), n);
      hi = t2 - tdiv(s * (t2 - v2), n);
      st.lo    = lo[VIEW_W-1:0];
      st.hi    = hi[VIEW_W-1:0];
      st.last  = (s == 0);
      st.fault = fault;
      if (s == 0 && r.has_tgt) begin
        st.lo = r.tgt_lo;
        st.hi = r.tgt_hi;
      end
      pending_steps.insert(pending_steps.size(), st);
    end
  endfunction

  // Register write, shadowed locally; the caller drops cfg_valid_i afterwards
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] dat);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= dat;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_NUM_STEPS:     sh_num_steps = dat[NSTEP_W-1:0];
      CFG_SAFETY_MARGIN: sh_margin    = dat[MARGIN_W-1:0];
      CFG_SCREEN_HEIGHT: sh_height    = dat[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Wait for the block to drain before touching the registers
  task automatic drain;
    wait (pending_steps.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Offer one request, idling at random beforehand
  task automatic send_req(zoom_req_t r);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    pointer_x_i       <= r.px;
    pointer_y_i       <= r.py;
    max_zoom_tenths_i <= r.zoom;
    view_low_i        <= r.vlo;
    view_high_i       <= r.vhi;
    do @(posedge clk_i); while (in_stall_o);
    plan_zoom(r);
    n_req_acc++;
  endtask

  function automatic logic signed [VIEW_W-1:0] rand_view();
    return VIEW_W'({$urandom, $urandom});
  endfunction

  // Random request shaped around the current screen geometry
  function automatic zoom_req_t rand_req();
    zoom_req_t r;
    int unsigned sel, hh, dsv;
    longint base, span;
    hh  = (sh_height == 0) ? 1 : sh_height;
    dsv = (sh_margin * sh_height) / 2048;
    sel = $urandom_range(99);
    r.has_tgt = 1'b0;
    r.tgt_lo  = '0;
    r.tgt_hi  = '0;
    r.zoom    = ($urandom_range(3) == 0) ? '0 : ZOOM_W'($urandom_range(1000));
    if (sel < 10) begin
      // raw noise over the whole field ranges
      r.px   = COORD_W'($urandom);
      r.py   = COORD_W'($urandom);
      r.zoom = ZOOM_W'($urandom);
      r.vlo  = rand_view();
      r.vhi  = rand_view();
    end else begin
      if (sel < 25 && hh > 2 * dsv + 4)
        r.px = COORD_W'((hh - 2 * dsv) / 2);         // equal spans when even
      else if (sel < 32)
        r.px = COORD_W'($signed($urandom_range(6)) - 3);  // near and below the floor
      else
        r.px = COORD_W'($urandom_range(hh));
      r.py = COORD_W'($signed($urandom_range(hh + 200)) - 100);
      base = longint'($signed($urandom)) * $urandom_range(4096);
      span = longint'($urandom_range(1 << 20)) * $urandom_range(1024);
      r.vlo = base[VIEW_W-1:0];
      r.vhi = VIEW_W'(base + span);
    end
    return r;
  endfunction

  // Output side: check each beat; stall at random, once for a long hold, never in a window
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i) begin
    zoom_step_t e;
    if (out_valid_o && !out_stall_i) begin
      n_beats <= n_beats + 1;
      if (pending_steps.size() == 0) begin
        $error("unexpected step beat lo=%0d hi=%0d", step_low_o, step_high_o);
        n_errors++;
      end else begin
        e = pending_steps[0];
        pending_steps.delete(0);
        if (step_low_o !== e.lo) begin
          $error("step_low exp %0d got %0d", e.lo, step_low_o);
          n_errors++;
        end
        if (step_high_o !== e.hi) begin
          $error("step_high exp %0d got %0d", e.hi, step_high_o);
          n_errors++;
        end
        if (last_step_o !== e.last) begin
          $error("last_step exp %0b got %0b", e.last, last_step_o);
          n_errors++;
        end
        if (geometry_fault_o !== e.fault) begin
          $error("geometry_fault exp %0b got %0b", e.fault, geometry_fault_o);
          n_errors++;
        end
      end
    end
    if (!hold_done && n_req_acc >= 40) begin
      hold_done = 1'b1;
      hold_left = STALL_HOLD;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (n_beats >= 600 && n_beats < 1100) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 37);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Directed requests, reset register values
  zoom_req_t dir_rows[] = '{
    '{21'sd1998, 21'sd1000, 10'd0, 48'sd0, 48'sd1000, 1'b1, -48'sd1048, -48'sd48},
    '{21'sd1998, 21'sd0, 10'd0, -48'sd500, 48'sd500, 1'b1, -48'sd2548, -48'sd1548},
    '{21'sd0, 21'sd2048, 10'd0, 48'sd0, 48'sd100000, 1'b0, '0, '0},
    '{-21'sd1048576, 21'sd2048, 10'd20, 48'sd0, 48'sd100000, 1'b0, '0, '0},
    '{21'sd1, 21'sd100, 10'd1000, -48'sd70000, 48'sd70000, 1'b0, '0, '0},
    '{21'sd1048575, 21'sd1048575, 10'd1, 48'sd0, 48'sd1, 1'b0, '0, '0},
    '{21'sd300, -21'sd1048576, 10'd10, -48'sd140737488355328,
      48'sd140737488355327, 1'b0, '0, '0},
    '{21'sd500, 21'sd4000, 10'd15, 48'sd140737488355327,
      -48'sd140737488355328, 1'b0, '0, '0},
    '{21'sd1000, 21'sd2048, 10'd1023, 48'sd1000000, 48'sd3000000, 1'b0, '0, '0},
    '{21'sd2, 21'sd2, 10'd0, 48'sd5, 48'sd5, 1'b0, '0, '0},
    '{21'sd2047, 21'sd2048, 10'd0, -48'sd1, 48'sd1, 1'b0, '0, '0},
    '{21'sd100, 21'sd1, 10'd512, 48'sd123456789, 48'sd987654321, 1'b0, '0, '0}
  };

  // Register settings per random phase: steps, margin, height
  logic [CFG_DATA_W-1:0] phase_cfg[5][3] = '{
    '{16'd0, 16'd0, 16'd1},
    '{16'hFFC0 | 16'd64, 16'd1024, 16'd65535},
    '{16'd127, 16'hF800 | 16'd2047, 16'd4096},
    '{16'd4, 16'd100, 16'd0},
    '{16'd3, 16'd25, 16'd8192}
  };

  initial begin
    zoom_req_t r;
    no_idle = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i]);
    in_valid_i <= 1'b0;
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_NUM_STEPS, phase_cfg[p][0]);
      write_reg(CFG_SAFETY_MARGIN, phase_cfg[p][1]);
      write_reg(CFG_SCREEN_HEIGHT, phase_cfg[p][2]);
      write_reg(CFG_SPARE_IDX, 16'($urandom));
      // the last two phases take a random steps value of 1 to 8
      if (p >= 3) write_reg(CFG_NUM_STEPS, 16'($urandom_range(1, 8)));
      cfg_valid_i <= 1'b0;
      for (int k = 0; k < ((p == 1) ? 12 : 50); k++) begin
        no_idle = (p == 4 && k < 30);
        r = rand_req();
        send_req(r);
      end
      in_valid_i <= 1'b0;
      no_idle = 1'b0;
      drain();
    end

    wait (pending_steps.size() == 0);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
